// ===== src/kns_pkg.sv =====
// ----------------------------------------------------------------------------
// kns_pkg: shared constants and types for the 0/1 knapsack solver
// Sizes of the profit row, keep-bit store and result fields, plus the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kns_pkg;

  localparam int MAX_ITEMS    = 32;
  localparam int MAX_CAPACITY = 255;
  localparam int PROFIT_BITS  = 16;

  // profit is taken from the low bits of the 16-bit input field
  localparam int PR_BITS     = (PROFIT_BITS < 16) ? PROFIT_BITS : 16;
  localparam int ROW_DEPTH   = MAX_CAPACITY + 1;
  localparam int CAP_BITS    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);
  localparam int IDX_BITS    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUM_BITS    =
    $clog2(longint'(MAX_ITEMS) * ((longint'(1) << PR_BITS) - 1) + 1);
  localparam int VALUE_BITS  = 21;
  localparam int CFG_BITS    = 8;
  localparam int WEIGHT_BITS = 8;

  localparam logic KIND_PROFIT = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  typedef struct packed {
    logic load;       // latch input beat, start sweep at top capacity
    logic step;       // issue one capacity of the row update
    logic finish;     // commit item: store weight, bump count
    logic tb_init;    // start traceback at used capacity
    logic tb_ev;      // evaluate one traceback read
    logic emit_prof;  // load profit result, rewind scan pointer
    logic emit_idx;   // load index result, advance scan pointer
    logic scan_next;  // advance scan pointer, nothing emitted
    logic clear;      // drop profit row and item count
  } cmd_t;

  typedef struct packed {
    logic add_ok;     // room for another item
    logic last_q;     // latched item closes the problem
    logic w_zero;     // sweep counter reached capacity zero
    logic pos_zero;   // traceback reached the first item
    logic scan_done;  // scan pointer past the last item
    logic scan_hit;   // item under scan pointer is selected
    logic out_free;   // output register can take a beat
  } sts_t;

endpackage

// ===== src/kns_ctrl.sv =====
// ----------------------------------------------------------------------------
// kns_ctrl: sequencer for the knapsack solver
// Steps through load, row sweep, traceback and result emission.
// ----------------------------------------------------------------------------
module kns_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  kns_pkg::sts_t sts,
  output kns_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_UPD   = 4'd2;
  localparam logic [3:0] ST_DRAIN = 4'd3;
  localparam logic [3:0] ST_TBI   = 4'd4;
  localparam logic [3:0] ST_TBRD  = 4'd5;
  localparam logic [3:0] ST_TBEV  = 4'd6;
  localparam logic [3:0] ST_PRD   = 4'd7;
  localparam logic [3:0] ST_POUT  = 4'd8;
  localparam logic [3:0] ST_SCAN  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts.add_ok) state_next = ST_UPD;
        else if (sts.last_q)     state_next = ST_TBI;
        else                     state_next = ST_IDLE;
      end
      ST_UPD: begin
        cmd.step = 1'b1;
        if (sts.w_zero) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.finish = 1'b1;
        state_next = sts.last_q ? ST_TBI : ST_IDLE;
      end
      ST_TBI: begin
        cmd.tb_init = 1'b1;
        state_next  = ST_TBRD;
      end
      ST_TBRD: begin
        // keep bit and weight are read here, used next cycle
        state_next = sts.pos_zero ? ST_PRD : ST_TBEV;
      end
      ST_TBEV: begin
        cmd.tb_ev  = 1'b1;
        state_next = ST_TBRD;
      end
      ST_PRD: begin
        state_next = ST_POUT;
      end
      ST_POUT: begin
        if (sts.out_free) begin
          cmd.emit_prof = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts.scan_done) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end else if (!sts.scan_hit) begin
          cmd.scan_next = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_idx = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/kns_dp.sv =====
// ----------------------------------------------------------------------------
// kns_dp: datapath for the knapsack solver
// Profit row memory with two read ports, keep-bit and weight stores,
// two-stage row update, traceback registers and the output register.
// ----------------------------------------------------------------------------
module kns_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [kns_pkg::CFG_BITS-1:0]        capacity,
  input  logic [kns_pkg::WEIGHT_BITS-1:0]     item_weight,
  input  logic [15:0]                         item_profit,
  input  logic                                last_item,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                kind,
  output logic [kns_pkg::VALUE_BITS-1:0]      value,
  output logic                                last,
  input  kns_pkg::cmd_t                       cmd,
  output kns_pkg::sts_t                       sts
);

  logic [kns_pkg::CFG_BITS-1:0]    cap_reg;
  logic [kns_pkg::CAP_BITS-1:0]    cap_used;

  logic [kns_pkg::WEIGHT_BITS-1:0] wt_q;
  logic [kns_pkg::PR_BITS-1:0]     pr_q;
  logic                            last_q;
  logic [kns_pkg::COUNT_BITS-1:0]  count;
  logic [kns_pkg::CAP_BITS-1:0]    w;
  logic [kns_pkg::COUNT_BITS-1:0]  pos;
  logic [kns_pkg::MAX_ITEMS-1:0]   sel_mask;

  // profit row store
  logic [kns_pkg::SUM_BITS-1:0]    row_mem [kns_pkg::ROW_DEPTH];
  logic [kns_pkg::ROW_DEPTH-1:0]   row_vld;
  logic [kns_pkg::CAP_BITS-1:0]    addr_a;
  logic [kns_pkg::CAP_BITS-1:0]    addr_b;
  logic [kns_pkg::SUM_BITS-1:0]    rd_a;
  logic [kns_pkg::SUM_BITS-1:0]    rd_b;
  logic                            va;
  logic                            vb;

  // update stage 1
  logic                            s1_valid;
  logic                            s1_fit;
  logic [kns_pkg::CAP_BITS-1:0]    s1_w;
  logic [kns_pkg::SUM_BITS-1:0]    old_val;
  logic [kns_pkg::SUM_BITS-1:0]    cand;
  logic                            take;
  logic                            fit;

  // keep bits and weights
  logic                            keep_mem [kns_pkg::MAX_ITEMS][kns_pkg::ROW_DEPTH];
  logic [kns_pkg::WEIGHT_BITS-1:0] wt_mem [kns_pkg::MAX_ITEMS];
  logic [kns_pkg::IDX_BITS-1:0]    wr_idx;
  logic [kns_pkg::IDX_BITS-1:0]    tb_idx;
  logic [kns_pkg::IDX_BITS-1:0]    scan_idx;
  logic                            kb_q;
  logic [kns_pkg::WEIGHT_BITS-1:0] wt_rd;

  logic [kns_pkg::MAX_ITEMS-1:0]   upper_sel;
  logic                            out_free;

  assign cap_used = kns_pkg::CAP_BITS'((cap_reg > kns_pkg::MAX_CAPACITY) ?
                                       kns_pkg::MAX_CAPACITY : int'(cap_reg));

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= kns_pkg::CFG_BITS'(255);
    end else if (cfg_valid && cfg_ready) begin
      cap_reg <= capacity;
    end
  end

  // ---- item latch, counters ----
  assign wr_idx   = kns_pkg::IDX_BITS'(count);
  assign tb_idx   = kns_pkg::IDX_BITS'(pos - 1'b1);
  assign scan_idx = kns_pkg::IDX_BITS'(pos);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wt_q   <= item_weight;
      pr_q   <= item_profit[kns_pkg::PR_BITS-1:0];
      last_q <= last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      w <= kns_pkg::CAP_BITS'(kns_pkg::MAX_CAPACITY);
    end else if (cmd.step) begin
      w <= w - 1'b1;
    end else if (cmd.tb_init) begin
      w <= cap_used;
    end else if (cmd.tb_ev && kb_q) begin
      w <= w - kns_pkg::CAP_BITS'(wt_rd);
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.tb_init) begin
      pos      <= count;
      sel_mask <= '0;
    end else if (cmd.tb_ev) begin
      pos <= pos - 1'b1;
      if (kb_q) sel_mask[tb_idx] <= 1'b1;
    end else if (cmd.emit_prof) begin
      pos <= '0;
    end else if (cmd.emit_idx || cmd.scan_next) begin
      pos <= pos + 1'b1;
    end
  end

  // ---- row update, stage 0: read row[w] and row[w - weight] ----
  assign fit    = ({1'b0, w} >= (kns_pkg::CAP_BITS+1)'(wt_q)) && (w != '0) &&
                  (w <= cap_used);
  assign addr_a = cmd.step ? w : cap_used;
  assign addr_b = w - kns_pkg::CAP_BITS'(wt_q);

  always_ff @(posedge clk) begin
    rd_a <= row_mem[addr_a];
    rd_b <= row_mem[addr_b];
    va   <= row_vld[addr_a];
    vb   <= row_vld[addr_b];
    s1_w <= w;
    s1_fit <= fit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.step;
    end
  end

  // ---- stage 1: compare and write back; ties leave the item out ----
  assign old_val = va ? rd_a : '0;
  assign cand    = kns_pkg::SUM_BITS'(pr_q) + (vb ? rd_b : '0);
  assign take    = s1_fit && (cand > old_val);

  always_ff @(posedge clk) begin
    if (s1_valid && take) row_mem[s1_w] <= cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (cmd.clear) begin
      row_vld <= '0;
    end else if (s1_valid && take) begin
      row_vld[s1_w] <= 1'b1;
    end
  end

  // every capacity gets its keep bit written, so stale rows never leak
  always_ff @(posedge clk) begin
    if (s1_valid) keep_mem[wr_idx][s1_w] <= take;
    if (cmd.finish) wt_mem[wr_idx] <= wt_q;
  end

  always_ff @(posedge clk) begin
    kb_q  <= keep_mem[tb_idx][w];
    wt_rd <= wt_mem[tb_idx];
  end

  // ---- output register ----
  assign out_free  = !out_valid || !out_stall;
  assign upper_sel = sel_mask >> (pos + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_prof || cmd.emit_idx) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_prof) begin
      kind  <= kns_pkg::KIND_PROFIT;
      value <= kns_pkg::VALUE_BITS'(va ? rd_a : '0);
      last  <= (sel_mask == '0);
    end else if (cmd.emit_idx) begin
      kind  <= kns_pkg::KIND_INDEX;
      value <= kns_pkg::VALUE_BITS'(pos) + 1'b1;
      last  <= (upper_sel == '0);
    end
  end

  always_comb begin
    sts           = '0;
    sts.add_ok    = (count < kns_pkg::COUNT_BITS'(kns_pkg::MAX_ITEMS));
    sts.last_q    = last_q;
    sts.w_zero    = (w == '0);
    sts.pos_zero  = (pos == '0);
    sts.scan_done = (pos == count);
    sts.scan_hit  = sel_mask[scan_idx];
    sts.out_free  = out_free;
  end

endmodule

// ===== src/knapsack_01_solver.sv =====
// ----------------------------------------------------------------------------
// knapsack_01_solver: 0/1 knapsack solver, dynamic programming over capacity
// Items stream in one per beat; the beat flagged last_item yields results.
// ----------------------------------------------------------------------------
// Usage:
//  - Write capacity on the cfg channel (valid/ready, always ready) while idle.
//  - Input beats (item_weight, item_profit, last_item) use in_valid/in_stall.
//    Each item sweeps the profit row one capacity per cycle from
//    MAX_CAPACITY down to 0. Items past MAX_ITEMS are dropped.
//  - After the last item a traceback walks back over the stored items,
//    then the result beats follow on out_valid/out_stall: maximum profit first
//    (kind 0), then selected 1-based indices ascending (kind 1); last marks
//    the final beat. The index scan visits each stored item in turn.
//  - A stalled output beat holds; the solver waits for the output register
//    and accepts the next item once the index scan has passed every item.
//  - Synchronous reset clears the profit row, item count, handshakes and
//    sets capacity to 255. The row is cleared again after each problem.
// ----------------------------------------------------------------------------
module knapsack_01_solver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kns_pkg::CFG_BITS-1:0]       capacity,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [kns_pkg::WEIGHT_BITS-1:0]    item_weight,
  input  logic [15:0]                        item_profit,
  input  logic                               last_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic [kns_pkg::VALUE_BITS-1:0]     value,
  output logic                               last
);

  kns_pkg::cmd_t cmd;
  kns_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  kns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kns_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .capacity    (capacity),
    .item_weight (item_weight),
    .item_profit (item_profit),
    .last_item   (last_item),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .kind        (kind),
    .value       (value),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts)
  );

  // a result beat is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_prof || cmd.emit_idx) |-> sts.out_free)
    else $error("result loaded over a pending beat");

  // commands from distinct phases never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.finish, cmd.tb_init, cmd.tb_ev,
              cmd.emit_prof, cmd.emit_idx, cmd.scan_next, cmd.clear}))
    else $error("overlapping datapath commands");

  // selected indices are 1-based and within the item store
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == kns_pkg::KIND_INDEX) |->
      (value != '0) && (value <= kns_pkg::VALUE_BITS'(kns_pkg::MAX_ITEMS)))
    else $error("selected index out of range");

  // a new item is only taken after the previous problem state was dropped
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> !in_stall)
    else $error("solver not idle after clear");

endmodule
